// ----- rtl/aes128_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box tables, GF(2^8) helpers and round-constant table.
// ----------------------------------------------------------------------------
package aes128_pkg;

	localparam int NumRounds = 10;
	localparam int BlockW    = 128;
	localparam int HalfW     = 64;
	localparam int CfgIdxW   = 1;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		KIND_ENC = 1'b0,
		KIND_DEC = 1'b1
	} kind_t;

	// Control carried alongside each cell's data
	typedef struct packed {
		logic  vld;
		kind_t kind;
	} cell_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
	};

	localparam logic [7:0] RCON [11] = '{
		8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
	};

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	// One column of MixColumns or InvMixColumns
	function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		logic [7:0] o [4];
		for (int k = 0; k < 4; k++) begin
			a[k]  = c[31-8*k -: 8];
			a2[k] = xt(a[k]);
			a4[k] = xt(a2[k]);
			a8[k] = xt(a4[k]);
			m2[k] = a2[k];
			m3[k] = a2[k] ^ a[k];
			m9[k] = a8[k] ^ a[k];
			mb[k] = a8[k] ^ a2[k] ^ a[k];
			md[k] = a8[k] ^ a4[k] ^ a[k];
			me[k] = a8[k] ^ a4[k] ^ a2[k];
		end
		for (int r = 0; r < 4; r++) begin
			if (inv)
				o[r] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
			else
				o[r] = m2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
		end
		mix_col = {o[0], o[1], o[2], o[3]};
	endfunction

	// SubWord(RotWord(w)) ^ rcon for the key schedule
	function automatic logic [31:0] key_core(input logic [31:0] w, input logic [7:0] rc);
		key_core = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
	endfunction

endpackage

// ----- rtl/aes128_key_sched.sv -----
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Pipelined expansion, one schedule step per stage, into eleven registered
// round keys; all keys are settled once the key has passed through every stage.
// ----------------------------------------------------------------------------
module aes128_key_sched import aes128_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [BlockW-1:0]     key,
	output logic [BlockW-1:0]     rk [NumRounds+1]
);

	logic [BlockW-1:0] rk_q [NumRounds+1];

	// One schedule step: previous round key to the next
	function automatic logic [BlockW-1:0] next_rk(input logic [BlockW-1:0] p,
		input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3;
		w0 = p[127:96] ^ key_core(p[31:0], rc);
		w1 = p[95:64] ^ w0;
		w2 = p[63:32] ^ w1;
		w3 = p[31:0] ^ w2;
		next_rk = {w0, w1, w2, w3};
	endfunction

	// Each stage derives its round key from the stage before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= NumRounds; g++) rk_q[g] <= '0;
		end else begin
			rk_q[0] <= key;
			for (int g = 1; g <= NumRounds; g++) rk_q[g] <= next_rk(rk_q[g-1], RCON[g]);
		end
	end

	for (genvar g = 0; g <= NumRounds; g++) begin : g_rk
		assign rk[g] = rk_q[g];
	end

endmodule

// ----- rtl/aes128_round_cell.sv -----
// ----------------------------------------------------------------------------
// AES-128 round cell
// One round of encryption or decryption; registers its result whenever enabled.
// ----------------------------------------------------------------------------
module aes128_round_cell import aes128_pkg::*; #(
	parameter bit IsLast = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  cell_ctl_t         ctl_in,
	input  logic [BlockW-1:0] data_in,
	input  logic [BlockW-1:0] enc_key,
	input  logic [BlockW-1:0] dec_key,
	output cell_ctl_t         ctl_out,
	output logic [BlockW-1:0] data_out
);

	logic [7:0]        b  [16];
	logic [7:0]        sh [16];
	logic [BlockW-1:0] sub_c, mixed_c, next_c;
	logic              dec;

	assign dec = (ctl_in.kind == KIND_DEC);

	// Byte view; index = column*4 + row
	always_comb begin
		for (int i = 0; i < 16; i++) b[i] = data_in[127-8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (dec) sh[((c+r)%4)*4+r] = b[c*4+r];
				else     sh[c*4+r]         = b[((c+r)%4)*4+r];
			end
		for (int i = 0; i < 16; i++)
			sub_c[127-8*i -: 8] = dec ? INV_SBOX[sh[i]] : SBOX[sh[i]];
	end

	// Encrypt: mix then add key; decrypt: add key then inverse mix; last round: add key, no mix
	always_comb begin
		logic [BlockW-1:0] pre;
		pre = dec ? (sub_c ^ dec_key) : sub_c;
		for (int c = 0; c < 4; c++)
			mixed_c[127-32*c -: 32] = mix_col(pre[127-32*c -: 32], dec);
		if (IsLast)
			next_c = sub_c ^ (dec ? dec_key : enc_key);
		else if (dec)
			next_c = mixed_c;
		else
			next_c = mixed_c ^ enc_key;
	end

	logic [BlockW-1:0] data_q;
	cell_ctl_t         ctl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= '0;
		else if (en) ctl_q <= ctl_in;
	end

	always_ff @(posedge clk) begin
		if (en) data_q <= next_c;
	end

	assign ctl_out  = ctl_q;
	assign data_out = data_q;

endmodule

// ----- rtl/aes128_block_cipher_top.sv -----
// ----------------------------------------------------------------------------
// AES-128 block cipher top level
// Ten round cells in a chain, one block entering every cycle while the input is ready.
// Each block passes the entry key-add stage, then the ten round cells.
// Throughput: one block per cycle; the whole chain stalls when the output is
// held, set by the single shared advance enable.
// Reset: arst_n clears keys to zero and all valid flags; chain data is unreset.
// Input is held off after reset and after each key register write while
// the round keys settle through the schedule pipeline.
// ----------------------------------------------------------------------------
module aes128_block_cipher_top import aes128_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [HalfW-1:0]   cfg_data,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [BlockW-1:0]  s_axis_tdata,  // block_high, block_low
	input  logic               s_axis_tuser,  // kind
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [BlockW-1:0]  m_axis_tdata   // result_high, result_low
);

	localparam logic [3:0] SettleCycles = 4'(NumRounds + 1);

	logic [HalfW-1:0]  key_high_q, key_low_q;
	logic [BlockW-1:0] rk [NumRounds+1];
	logic              adv;
	logic [3:0]        settle_q;

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Round-key settle count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)               settle_q <= SettleCycles;
		else if (cfg_we)           settle_q <= SettleCycles;
		else if (settle_q != 4'd0) settle_q <= settle_q - 4'd1;
	end

	aes128_key_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.key    ({key_high_q, key_low_q}),
		.rk     (rk)
	);

	cell_ctl_t         ctl  [NumRounds+1];
	logic [BlockW-1:0] data [NumRounds+1];
	logic              kdec;

	// Chain advances whenever the last cell is empty or drained
	assign adv           = !ctl[NumRounds].vld || m_axis_tready;
	assign s_axis_tready = adv && (settle_q == 4'd0);

	// Entry stage: initial key add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl[0] <= '0;
		else if (adv) ctl[0] <= '{vld: s_axis_tvalid && s_axis_tready,
			kind: kind_t'(s_axis_tuser)};
	end

	assign kdec = s_axis_tuser;

	always_ff @(posedge clk) begin
		if (adv) data[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]}
			^ (kdec ? rk[NumRounds] : rk[0]);
	end

	for (genvar g = 1; g <= NumRounds; g++) begin : g_cell
		aes128_round_cell #(.IsLast(g == NumRounds)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.ctl_in   (ctl[g-1]),
			.data_in  (data[g-1]),
			.enc_key  (rk[g]),
			.dec_key  (rk[NumRounds-g]),
			.ctl_out  (ctl[g]),
			.data_out (data[g])
		);
	end

	assign m_axis_tvalid = ctl[NumRounds].vld;
	assign m_axis_tdata  = {data[NumRounds][63:0], data[NumRounds][127:64]};

	// A held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// Stall reaches the input side
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");
	// Entry stage mirrors an accepted transfer
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ctl[0].vld)
		else $error("accepted transfer lost");

endmodule
